### hw/rtl/pwdo_pkg.sv
`timescale 1ns / 1ps
package pwdo_pkg;

  localparam int unsigned KIND_W   = 2;
  localparam int unsigned SLOT_W   = 11;
  localparam int unsigned DATA_W   = 64;
  localparam int unsigned PA_W     = 52;
  localparam int unsigned OFS_W    = 63;
  localparam int unsigned VA_W     = 32;
  localparam int unsigned LEFT_W   = 23;
  localparam int unsigned STAT_W   = 3;
  localparam int unsigned CNT_W    = 5;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [KIND_W-1:0] KIND_LOAD_DIR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD_SEG = 2'd1;
  localparam logic [KIND_W-1:0] KIND_XLATE    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ENTRY    = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK          = 3'd0;
  localparam logic [STAT_W-1:0] ST_DIR_INVALID = 3'd1;
  localparam logic [STAT_W-1:0] ST_ENT_INVALID = 3'd2;
  localparam logic [STAT_W-1:0] ST_ENT_NO_DUMP = 3'd3;
  localparam logic [STAT_W-1:0] ST_ADDR_NO_DUMP = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_PAE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RAW     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_PRES = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SEG_CNT = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic dir_read;   // read directory for the held virtual address
    logic eval;       // resolve the held item into a physical address
    logic seg_step;   // look at one segment entry
    logic emit;       // latch the result into the output register
  } pwdo_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_search; // a physical address must go through the segment table
    logic search_done; // the search found a hit or ran out
  } pwdo_stat_t;

endpackage

### hw/rtl/pwdo_ctrl.sv
`timescale 1ns / 1ps
module pwdo_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [1:0]           start_kind,
  input  logic                 out_busy,
  input  pwdo_pkg::pwdo_stat_t stat,
  output pwdo_pkg::pwdo_cmd_t  cmd,
  output logic                 idle
);
  import pwdo_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_DIR, S_EVAL, S_SEARCH, S_EMIT} state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (start_kind == KIND_XLATE) state_nxt = S_DIR;
          else if (start_kind == KIND_ENTRY) state_nxt = S_EVAL;
        end
      end
      S_DIR: begin
        cmd.dir_read = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        state_nxt = S_SEARCH;
      end
      S_SEARCH: begin
        if (!stat.need_search || stat.search_done) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.seg_step = 1'b1;
        end
      end
      S_EMIT: begin
        if (!out_busy) begin
          cmd.emit = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign idle = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### hw/rtl/pwdo_dp.sv
`timescale 1ns / 1ps
module pwdo_dp #(
  parameter int unsigned MAX_SEGMENTS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic [pwdo_pkg::KIND_W-1:0]   kind,
  input  logic [pwdo_pkg::SLOT_W-1:0]   slot,
  input  logic [pwdo_pkg::DATA_W-1:0]   entry_data,
  input  logic [pwdo_pkg::PA_W-1:0]     seg_phys_base,
  input  logic [pwdo_pkg::PA_W-1:0]     seg_length,
  input  logic [pwdo_pkg::OFS_W-1:0]    seg_file_base,
  input  logic [pwdo_pkg::VA_W-1:0]     virt_addr,
  input  logic                          pae_mode,
  input  logic                          raw_dump,
  input  logic                          dir_present,
  input  logic [pwdo_pkg::CNT_W-1:0]    seg_count,
  input  pwdo_pkg::pwdo_cmd_t           cmd,
  output pwdo_pkg::pwdo_stat_t          stat,
  output logic                          res_valid,
  output logic                          res_kind,
  output logic [pwdo_pkg::OFS_W-1:0]    res_ofs,
  output logic [pwdo_pkg::LEFT_W-1:0]   res_left,
  output logic [pwdo_pkg::STAT_W-1:0]   res_status,
  input  logic                          res_taken
);
  import pwdo_pkg::*;

  localparam int unsigned SEG_IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned SEG_CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned SEG_RANGE_W = (SEG_CNT_W > CNT_W) ? SEG_CNT_W : CNT_W;
  localparam int unsigned DIR_DEPTH = 2048;

  logic [DATA_W-1:0] dir_mem [DIR_DEPTH];
  logic [PA_W-1:0]   sb_mem  [MAX_SEGMENTS];
  logic [PA_W-1:0]   sl_mem  [MAX_SEGMENTS];
  logic [OFS_W-1:0]  sf_mem  [MAX_SEGMENTS];

  logic [DATA_W-1:0] pde_r;
  logic [VA_W-1:0]   va_r;
  logic [DATA_W-1:0] ent_r;
  logic              is_entry_r;
  logic              pend_r;
  logic [11:0]       pofs_r;

  logic [PA_W-1:0]   pa_r;
  logic [LEFT_W-1:0] left_r;
  logic              fin_r;      // final translation vs table-entry request
  logic              direct_r;   // result known without segment search
  logic [STAT_W-1:0] dstat_r;
  logic              need_r;
  logic              done_r;
  logic              hit_r;
  logic [OFS_W-1:0]  hofs_r;
  logic [SEG_CNT_W-1:0] idx_r;
  logic              drop_r;     // entry data with no walk pending

  logic [SEG_RANGE_W-1:0] lim;
  logic [SEG_CNT_W-1:0]   nseg;

  // Stores and request capture.
  always_ff @(posedge clk) begin
    if (accept && kind == KIND_LOAD_DIR) dir_mem[slot] <= entry_data;
    if (accept && kind == KIND_LOAD_SEG &&
        {{(32-SLOT_W){1'b0}}, slot} < 32'(MAX_SEGMENTS)) begin
      sb_mem[slot[SEG_IDX_W-1:0]] <= seg_phys_base;
      sl_mem[slot[SEG_IDX_W-1:0]] <= seg_length;
      sf_mem[slot[SEG_IDX_W-1:0]] <= seg_file_base;
    end
    if (accept) begin
      va_r       <= virt_addr;
      ent_r      <= entry_data;
      is_entry_r <= (kind == KIND_ENTRY);
    end
    if (cmd.dir_read) begin
      if (pae_mode) pde_r <= dir_mem[va_r[31:21]];
      else          pde_r <= dir_mem[{1'b0, va_r[31:22]}];
    end
  end

  // Evaluation of the held item.
  logic [PA_W-1:0]   e_pa;
  logic [LEFT_W-1:0] e_left;
  logic              e_fin, e_direct;
  logic [STAT_W-1:0] e_stat;
  logic [DATA_W-1:0] pde_m, pte_m;

  always_comb begin
    e_pa = '0;
    e_left = '0;
    e_fin = 1'b1;
    e_direct = 1'b0;
    e_stat = ST_OK;
    pde_m = pae_mode ? pde_r : {32'd0, pde_r[31:0]};
    pte_m = pae_mode ? ent_r : {32'd0, ent_r[31:0]};
    if (is_entry_r) begin
      if (!pte_m[0]) begin
        e_direct = 1'b1;
        e_stat = ST_ENT_INVALID;
      end else begin
        e_pa = {pte_m[51:12], pofs_r};
        e_left = LEFT_W'(13'h1000 - {1'b0, pofs_r});
      end
    end else if (!dir_present) begin
      e_pa = {20'd0, va_r};
      e_left = LEFT_W'(13'h1000 - {1'b0, va_r[11:0]});
    end else if (!pde_m[0]) begin
      e_direct = 1'b1;
      e_stat = ST_DIR_INVALID;
    end else if (pae_mode) begin
      if (pde_m[7]) begin
        e_pa = {pde_m[51:21], va_r[20:0]};
        e_left = LEFT_W'(22'h200000 - {1'b0, va_r[20:0]});
      end else begin
        e_fin = 1'b0;
        e_pa = {pde_m[51:12], va_r[20:12], 3'b000};
      end
    end else begin
      if (pde_m[7]) begin
        e_pa = {20'd0, pde_m[31:22], va_r[21:0]};
        e_left = LEFT_W'(23'h400000 - {1'b0, va_r[21:0]});
      end else begin
        e_fin = 1'b0;
        e_pa = {20'd0, pde_m[31:12], va_r[21:12], 2'b00};
      end
    end
  end

  assign lim  = (SEG_RANGE_W'(seg_count) > SEG_RANGE_W'(MAX_SEGMENTS)) ?
                SEG_RANGE_W'(MAX_SEGMENTS) : SEG_RANGE_W'(seg_count);
  assign nseg = SEG_CNT_W'(lim);

  // One segment compare per cycle.
  logic [SEG_IDX_W-1:0] sidx;
  logic [PA_W:0]        s_end;
  logic                 s_hit;
  assign sidx  = idx_r[SEG_IDX_W-1:0];
  assign s_end = {1'b0, sb_mem[sidx]} + {1'b0, sl_mem[sidx]};
  assign s_hit = (pa_r >= sb_mem[sidx]) && ({1'b0, pa_r} < s_end);

  assign stat.need_search = need_r;
  assign stat.search_done = done_r;

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      pa_r     <= e_pa;
      left_r   <= e_left;
      fin_r    <= e_fin;
      dstat_r  <= e_stat;
      idx_r    <= '0;
      hit_r    <= 1'b0;
      drop_r   <= is_entry_r && !pend_r;
      direct_r <= e_direct || (is_entry_r && !pend_r);
      need_r   <= !(e_direct || (is_entry_r && !pend_r)) && !raw_dump;
      done_r   <= (nseg == '0);
      hofs_r   <= OFS_W'(e_pa);
    end else if (cmd.seg_step) begin
      if (s_hit) begin
        hit_r  <= 1'b1;
        done_r <= 1'b1;
        hofs_r <= OFS_W'(pa_r - sb_mem[sidx]) + sf_mem[sidx];
      end else begin
        idx_r  <= idx_r + 1'b1;
        done_r <= ((idx_r + 1'b1) == nseg);
      end
    end
  end

  // Walk state and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r    <= 1'b0;
      pofs_r    <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_taken) res_valid <= 1'b0;
      if (cmd.emit) begin
        if (!drop_r) res_valid <= 1'b1;
        if (is_entry_r) begin
          if (!drop_r) pend_r <= 1'b0;
        end else begin
          pend_r <= 1'b0;
          if (!direct_r && !fin_r && (raw_dump || hit_r)) begin
            pend_r <= 1'b1;
            pofs_r <= va_r[11:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (direct_r) begin
        res_kind <= 1'b1; res_ofs <= '0; res_left <= '0; res_status <= dstat_r;
      end else if (raw_dump || hit_r) begin
        res_kind   <= fin_r;
        res_ofs    <= raw_dump ? OFS_W'(pa_r) : hofs_r;
        res_left   <= fin_r ? left_r : '0;
        res_status <= ST_OK;
      end else begin
        res_kind <= 1'b1; res_ofs <= '0; res_left <= '0;
        res_status <= fin_r ? ST_ADDR_NO_DUMP : ST_ENT_NO_DUMP;
      end
    end
  end

endmodule

### hw/rtl/page_walk_to_dump_offset.sv
`timescale 1ns / 1ps
// Loads are stored on acceptance, leaving the controller idle. A translate request passes
// directory read, evaluation, segment search and emit; a table-entry request skips the directory
// read. The single segment comparator checks up to MAX_SEGMENTS segments one at a time. One
// request is in work at a time; the result register lets the next one enter once it is written.
// Reset (rst_n low, synchronous) clears the controller, pending walk and config.
module page_walk_to_dump_offset #(
  parameter int unsigned MAX_SEGMENTS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [pwdo_pkg::KIND_W-1:0]     in_kind,
  input  logic [pwdo_pkg::SLOT_W-1:0]     in_slot,
  input  logic [pwdo_pkg::DATA_W-1:0]     in_entry_data,
  input  logic [pwdo_pkg::PA_W-1:0]       in_seg_phys_base,
  input  logic [pwdo_pkg::PA_W-1:0]       in_seg_length,
  input  logic [pwdo_pkg::OFS_W-1:0]      in_seg_file_base,
  input  logic [pwdo_pkg::VA_W-1:0]       in_virt_addr,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_result_kind,
  output logic [pwdo_pkg::OFS_W-1:0]      out_file_offset,
  output logic [pwdo_pkg::LEFT_W-1:0]     out_bytes_left,
  output logic [pwdo_pkg::STAT_W-1:0]     out_status,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pwdo_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pwdo_pkg::CNT_W-1:0]      cfg_data
);
  import pwdo_pkg::*;

  logic pae_r, raw_r, dirp_r;
  logic [CNT_W-1:0] cnt_r;
  pwdo_cmd_t cmd;
  pwdo_stat_t stat;
  logic idle, accept;

  // Requests enter only while the controller is idle.
  assign in_stall  = !idle;
  assign accept    = in_valid && idle;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pae_r <= 1'b0; raw_r <= 1'b0; dirp_r <= 1'b0; cnt_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_PAE:      pae_r  <= cfg_data[0];
        CFG_RAW:      raw_r  <= cfg_data[0];
        CFG_DIR_PRES: dirp_r <= cfg_data[0];
        CFG_SEG_CNT:  cnt_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  pwdo_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(accept), .start_kind(in_kind),
    .out_busy(out_valid && out_stall), .stat(stat), .cmd(cmd), .idle(idle)
  );

  pwdo_dp #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_dp (
    .clk(clk), .rst_n(rst_n), .accept(accept), .kind(in_kind), .slot(in_slot),
    .entry_data(in_entry_data), .seg_phys_base(in_seg_phys_base),
    .seg_length(in_seg_length), .seg_file_base(in_seg_file_base),
    .virt_addr(in_virt_addr), .pae_mode(pae_r), .raw_dump(raw_r),
    .dir_present(dirp_r), .seg_count(cnt_r), .cmd(cmd), .stat(stat),
    .res_valid(out_valid), .res_kind(out_result_kind), .res_ofs(out_file_offset),
    .res_left(out_bytes_left), .res_status(out_status),
    .res_taken(out_valid && !out_stall)
  );

endmodule
